// ----- hdl/tfr_pkg.sv -----
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types, codes and helpers for the streaming text find-and-replace.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam logic [7:0]  NEWLINE   = 8'h0A;
    localparam logic [23:0] LINE_ONE  = 24'd1;
    localparam logic [23:0] LINE_TOP  = 24'hFFFFFF;
    localparam logic [3:0]  REPL_MAX  = 4'd8;

    // Match mode codes; the unused code behaves as plain.
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_PREFIX = 2'd1;
    localparam logic [1:0] MODE_SUFFIX = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SEARCH_PATTERN = 3'd0;
    localparam logic [2:0] REG_SEARCH_LENGTH  = 3'd1;
    localparam logic [2:0] REG_REPLACEMENT    = 3'd2;
    localparam logic [2:0] REG_REPL_LENGTH    = 3'd3;
    localparam logic [2:0] REG_MATCH_MODE     = 3'd4;
    localparam logic [2:0] REG_FIRST_LINE     = 3'd5;
    localparam logic [2:0] REG_LAST_LINE      = 3'd6;

    // Request from the sequencer to the output stage.
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       close;
    } tfr_emit_t;

    // Word boundary: NUL, white space, space and ASCII punctuation.
    function automatic logic is_boundary(input logic [7:0] c);
        return (c == 8'd0) || (c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd47) ||
               (c >= 8'd58 && c <= 8'd64) || (c >= 8'd91 && c <= 8'd96) ||
               (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

// ----- hdl/text_find_replace_stream.sv -----
// ----------------------------------------------------------------------------
// text_find_replace_stream
// Streaming find-and-replace over text bytes with line range and word modes.
// ----------------------------------------------------------------------------
// One text byte is taken per request and the edited text leaves as zero or
// more bytes, the final one of each run flagged on m_tlast. A small sequencer
// works through each byte in turn: it checks the pending match, appends the
// byte to the candidate window, gives up candidate bytes one at a time until
// the window is again a prefix of the pattern, and finishes with the line end
// and end-of-text flushes. Every output byte passes through one shared output
// step, one byte per cycle while the output is not stalled, with bytes held
// ahead of the candidate (the word part in suffix mode) read from a small
// memory through a read state and an emit state per byte. The block takes no
// new byte until its run is handed to the output register, which may still
// hold the final byte while the next byte is accepted. The held-word memory
// has no reset and needs no clearing. Configuration must be written through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module text_find_replace_stream
    import tfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int WORD_MAX    = 32
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte [7:0]
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast    // last_of_run
);

    // Sizes of the held-word memory and of the candidate window.
    localparam int PRE_N  = WORD_MAX + 1;
    localparam int PIDX_W = $clog2(PRE_N);
    localparam int CNT_W  = $clog2(PRE_N + 1);
    localparam int CAND_N = PATTERN_MAX + 1;
    localparam int CIDX_W = (CAND_N > 1) ? $clog2(CAND_N) : 1;
    localparam int CCNT_W = $clog2(CAND_N + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BEGIN, S_MD2, S_APPEND, S_REL, S_FIN, S_NL, S_EOT, S_DONE,
        S_JPRE_RD, S_JPRE_EM, S_JCAND, S_JREPL, S_JBYTE
    } state_t;

    // Configuration registers.
    logic [63:0] search_pattern_reg;
    logic [3:0]  search_length_reg;
    logic [63:0] replacement_reg;
    logic [3:0]  replacement_length_reg;
    logic [1:0]  match_mode_reg;
    logic [23:0] first_line_reg;
    logic [23:0] last_line_reg;

    // Control state.
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [23:0]         line_reg, line_next;
    logic [CNT_W-1:0]    pre_cnt_reg, pre_cnt_next;
    logic [CCNT_W-1:0]   cand_cnt_reg, cand_cnt_next;
    logic                drop_reg, drop_next;
    logic                at_ws_reg, at_ws_next;
    logic [CNT_W-1:0]    j_idx_reg, j_idx_next;

    // Current request and output job description.
    logic [7:0]          byte_reg;
    logic                eot_reg;
    logic                edit_reg;
    logic [CNT_W-1:0]    job_pre_reg;
    logic [CCNT_W-1:0]   job_cand_reg;
    logic                job_repl_reg;
    logic                job_byte_v_reg;
    logic [7:0]          job_byte_reg;

    // Candidate window and held-word memory.
    logic [7:0]          cand_reg [CAND_N];
    logic [7:0]          pre_mem [PRE_N];
    logic [7:0]          rd_data_reg;

    // Combinational helpers.
    logic [3:0]          pat_len;
    logic [3:0]          rlen;
    logic                md1, md2;
    logic                prefix_ok, cand_complete;
    logic                bnd_b, bnd_c;
    logic                flush_repl;
    logic                emit_ok;
    tfr_emit_t           emit;
    logic                mem_we, cand_shift, cand_wr;
    logic                launch, do_flush;
    logic [CNT_W-1:0]    l_pre;
    logic [CCNT_W-1:0]   l_cand;
    logic                l_repl, l_byte_v;
    logic [7:0]          l_byte;
    state_t              l_ret;
    logic                accept;
    logic                edit_now;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign pat_len = (search_length_reg > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX)
                                                           : search_length_reg;
    assign rlen    = (replacement_length_reg > REPL_MAX) ? REPL_MAX : replacement_length_reg;
    assign md1     = (match_mode_reg == MODE_PREFIX);
    assign md2     = (match_mode_reg == MODE_SUFFIX);
    assign bnd_b   = is_boundary(byte_reg);
    assign bnd_c   = is_boundary(cand_reg[0]);

    assign edit_now = (pat_len != 4'd0) && (line_reg >= first_line_reg) &&
                      (line_reg <= last_line_reg);

    // The window is a match in progress when each of its bytes equals the
    // pattern byte at the same place.
    always_comb begin
        prefix_ok = (int'(cand_cnt_reg) <= int'(pat_len));
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i < int'(cand_cnt_reg) && cand_reg[i] != search_pattern_reg[8*i +: 8]) begin
                prefix_ok = 1'b0;
            end
        end
    end

    assign cand_complete = (pat_len != 4'd0) && (int'(cand_cnt_reg) == int'(pat_len)) &&
                           prefix_ok;
    // A complete suffix-mode match replaces the whole word at a flush.
    assign flush_repl    = md2 && cand_complete && !drop_reg;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        line_next     = line_reg;
        pre_cnt_next  = pre_cnt_reg;
        cand_cnt_next = cand_cnt_reg;
        drop_next     = drop_reg;
        at_ws_next    = at_ws_reg;
        j_idx_next    = j_idx_reg;
        emit          = '0;
        mem_we        = 1'b0;
        cand_shift    = 1'b0;
        cand_wr       = 1'b0;
        launch        = 1'b0;
        do_flush      = 1'b0;
        l_pre         = '0;
        l_cand        = '0;
        l_repl        = 1'b0;
        l_byte_v      = 1'b0;
        l_byte        = byte_reg;
        l_ret         = S_DONE;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (!edit_reg) begin
                    // Outside the edited lines: flush, then pass the byte on.
                    do_flush = 1'b1;
                    l_byte_v = 1'b1;
                    l_ret    = S_NL;
                end else if (md1 && drop_reg && !bnd_b) begin
                    // Tail of a replaced word is discarded.
                    state_next = S_NL;
                end else begin
                    if (md1 && drop_reg) begin
                        drop_next = 1'b0;
                    end
                    state_next = S_MD2;
                end
            end
            S_MD2: begin
                if (md2 && cand_complete) begin
                    // The new byte decides whether the match ended a word.
                    launch        = 1'b1;
                    l_repl        = bnd_b && !drop_reg;
                    l_pre         = l_repl ? '0 : pre_cnt_reg;
                    l_cand        = l_repl ? '0 : cand_cnt_reg;
                    l_ret         = S_APPEND;
                    pre_cnt_next  = '0;
                    cand_cnt_next = '0;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND: begin
                cand_wr       = 1'b1;
                cand_cnt_next = cand_cnt_reg + CCNT_W'(1);
                state_next    = S_REL;
            end
            S_REL: begin
                if (cand_cnt_reg != '0 && !prefix_ok) begin
                    cand_shift    = 1'b1;
                    cand_cnt_next = cand_cnt_reg - CCNT_W'(1);
                    if (md2 && !bnd_c) begin
                        // The byte joins the word held ahead of the window.
                        mem_we       = 1'b1;
                        pre_cnt_next = pre_cnt_reg + CNT_W'(1);
                        if (int'(pre_cnt_reg) + 1 > WORD_MAX) begin
                            // Word too long: release it and stop editing it.
                            launch       = 1'b1;
                            l_pre        = pre_cnt_reg + CNT_W'(1);
                            l_ret        = S_REL;
                            pre_cnt_next = '0;
                            drop_next    = 1'b1;
                        end
                    end else begin
                        launch       = 1'b1;
                        l_pre        = pre_cnt_reg;
                        l_byte_v     = 1'b1;
                        l_byte       = cand_reg[0];
                        l_ret        = S_REL;
                        pre_cnt_next = '0;
                        at_ws_next   = bnd_c;
                        if (md2) begin
                            drop_next = 1'b0;
                        end
                    end
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!md2 && cand_complete) begin
                    launch = 1'b1;
                    l_ret  = S_NL;
                    if (md1 && !at_ws_reg) begin
                        l_pre  = pre_cnt_reg;
                        l_cand = cand_cnt_reg;
                    end else begin
                        l_repl = 1'b1;
                        if (md1) begin
                            drop_next = 1'b1;
                        end
                    end
                    pre_cnt_next  = '0;
                    cand_cnt_next = '0;
                    at_ws_next    = 1'b1;
                end else begin
                    state_next = S_NL;
                end
            end
            S_NL: begin
                if (byte_reg == NEWLINE) begin
                    do_flush = 1'b1;
                    l_ret    = S_EOT;
                    if (line_reg < LINE_TOP) begin
                        line_next = line_reg + 24'd1;
                    end
                end else begin
                    state_next = S_EOT;
                end
            end
            S_EOT: begin
                if (eot_reg) begin
                    do_flush  = 1'b1;
                    l_ret     = S_DONE;
                    line_next = LINE_ONE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                emit.close = 1'b1;
                if (emit_ok) begin
                    state_next = S_IDLE;
                end
            end
            S_JPRE_RD: begin
                if (int'(j_idx_reg) >= int'(job_pre_reg)) begin
                    j_idx_next = '0;
                    state_next = S_JCAND;
                end else begin
                    state_next = S_JPRE_EM;
                end
            end
            S_JPRE_EM: begin
                emit.push = 1'b1;
                emit.data = rd_data_reg;
                if (emit_ok) begin
                    j_idx_next = j_idx_reg + CNT_W'(1);
                    state_next = S_JPRE_RD;
                end
            end
            S_JCAND: begin
                if (int'(j_idx_reg) >= int'(job_cand_reg)) begin
                    j_idx_next = '0;
                    state_next = S_JREPL;
                end else begin
                    emit.push = 1'b1;
                    emit.data = cand_reg[j_idx_reg[CIDX_W-1:0]];
                    if (emit_ok) begin
                        j_idx_next = j_idx_reg + CNT_W'(1);
                    end
                end
            end
            S_JREPL: begin
                if (!job_repl_reg || int'(j_idx_reg) >= int'(rlen)) begin
                    state_next = S_JBYTE;
                end else begin
                    emit.push = 1'b1;
                    emit.data = replacement_reg[8*j_idx_reg[2:0] +: 8];
                    if (emit_ok) begin
                        j_idx_next = j_idx_reg + CNT_W'(1);
                    end
                end
            end
            S_JBYTE: begin
                if (job_byte_v_reg) begin
                    emit.push = 1'b1;
                    emit.data = job_byte_reg;
                    if (emit_ok) begin
                        state_next = ret_reg;
                    end
                end else begin
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Full flush of everything held, as at a line end.
        if (do_flush) begin
            launch        = 1'b1;
            l_repl        = flush_repl;
            l_pre         = flush_repl ? '0 : pre_cnt_reg;
            l_cand        = flush_repl ? '0 : cand_cnt_reg;
            pre_cnt_next  = '0;
            cand_cnt_next = '0;
            drop_next     = 1'b0;
            at_ws_next    = 1'b1;
        end

        if (launch) begin
            j_idx_next = '0;
            ret_next   = l_ret;
            state_next = S_JPRE_RD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= S_IDLE;
            ret_reg                <= S_DONE;
            line_reg               <= LINE_ONE;
            pre_cnt_reg            <= '0;
            cand_cnt_reg           <= '0;
            drop_reg               <= 1'b0;
            at_ws_reg              <= 1'b1;
            j_idx_reg              <= '0;
            search_pattern_reg     <= '0;
            search_length_reg      <= 4'd1;
            replacement_reg        <= '0;
            replacement_length_reg <= '0;
            match_mode_reg         <= MODE_PLAIN;
            first_line_reg         <= LINE_ONE;
            last_line_reg          <= LINE_TOP;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            line_reg     <= line_next;
            pre_cnt_reg  <= pre_cnt_next;
            cand_cnt_reg <= cand_cnt_next;
            drop_reg     <= drop_next;
            at_ws_reg    <= at_ws_next;
            j_idx_reg    <= j_idx_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SEARCH_PATTERN: search_pattern_reg     <= cfg_wdata;
                    REG_SEARCH_LENGTH:  search_length_reg      <= cfg_wdata[3:0];
                    REG_REPLACEMENT:    replacement_reg        <= cfg_wdata;
                    REG_REPL_LENGTH:    replacement_length_reg <= cfg_wdata[3:0];
                    REG_MATCH_MODE:     match_mode_reg         <= cfg_wdata[1:0];
                    REG_FIRST_LINE:     first_line_reg         <= cfg_wdata[23:0];
                    REG_LAST_LINE:      last_line_reg          <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
        end
    end

    // Request payload and job description; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
            edit_reg <= edit_now;
        end
        if (launch) begin
            job_pre_reg    <= l_pre;
            job_cand_reg   <= l_cand;
            job_repl_reg   <= l_repl;
            job_byte_v_reg <= l_byte_v;
            job_byte_reg   <= l_byte;
        end
    end

    // Candidate window: shifts down as bytes are given up.
    always_ff @(posedge aclk) begin
        if (cand_shift) begin
            for (int i = 0; i < CAND_N - 1; i++) begin
                cand_reg[i] <= cand_reg[i + 1];
            end
        end else if (cand_wr) begin
            cand_reg[cand_cnt_reg[CIDX_W-1:0]] <= byte_reg;
        end
    end

    // Held-word memory, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pre_mem[pre_cnt_reg[PIDX_W-1:0]] <= cand_reg[0];
        end
        rd_data_reg <= pre_mem[j_idx_reg[PIDX_W-1:0]];
    end

    tfr_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .emit_ok  (emit_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Accepting a request moves the block out of the idle state, so it drops ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready straight after a request");

    // The held word never outgrows the memory.
    a_pre_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(pre_cnt_reg) <= WORD_MAX)
        else $error("held word count beyond limit");

    // Between requests the window never exceeds the pattern length limit.
    a_cand_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (int'(cand_cnt_reg) <= PATTERN_MAX))
        else $error("candidate window too long while idle");

endmodule

// ----- hdl/tfr_emit.sv -----
// ----------------------------------------------------------------------------
// tfr_emit
// Output stage: holds one byte back so that the final byte of a run can be
// marked, and registers the result request towards the stream.
// ----------------------------------------------------------------------------
module tfr_emit
    import tfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tfr_emit_t emit,
    output logic      emit_ok,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic      m_tlast     // last_of_run
);

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       pend_v_reg;
    logic [7:0] pend_reg;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_ok  = !pend_v_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (emit.push && emit_ok) begin
                if (pend_v_reg) begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= pend_reg;
                    m_tlast_reg  <= 1'b0;
                end
                pend_reg   <= emit.data;
                pend_v_reg <= 1'b1;
            end else if (emit.close && pend_v_reg && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= pend_reg;
                m_tlast_reg  <= 1'b1;
                pend_v_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
